// ===== rtl/dlrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlrc_pkg
// Shared types, codes and arithmetic helpers of the dimmer level ramp
// controller.
// ----------------------------------------------------------------------------
package dlrc_pkg;

    // command codes on the op field
    localparam logic [3:0] OP_ON     = 4'd0;
    localparam logic [3:0] OP_OFF    = 4'd1;
    localparam logic [3:0] OP_TOGGLE = 4'd2;
    localparam logic [3:0] OP_MTL    = 4'd3;
    localparam logic [3:0] OP_MOVE   = 4'd4;
    localparam logic [3:0] OP_STOP   = 4'd5;
    localparam logic [3:0] OP_TICK   = 4'd6;
    localparam logic [3:0] OP_REPORT = 4'd7;

    // report kinds
    localparam logic [1:0] RPT_BOOL  = 2'd0;
    localparam logic [1:0] RPT_VALUE = 2'd1;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNKNOWN   = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    // write kinds
    localparam logic WK_BOOL  = 1'b0;
    localparam logic WK_VALUE = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_CHANNEL   = 2'd0;
    localparam logic [1:0] REG_ONOFF_OVR = 2'd1;
    localparam logic [1:0] REG_LEVEL_OVR = 2'd2;

    localparam logic [3:0] CHANNEL_RESET  = 4'd1;
    localparam logic [7:0] ONOFF_ID_DEF   = 8'h01;
    localparam logic [7:0] LEVEL_ID_BASE  = 8'h07;
    localparam logic [7:0] LEVEL_ID_DEF   = 8'h08;

    localparam logic [7:0] LEVEL_MAX   = 8'd254;
    localparam logic [9:0] BRIGHT_MAX  = 10'd1000;
    localparam logic [7:0] RAMP_STEP   = 8'd12;

    // reciprocals: x/127 as (x*M)>>24 exact for x < 2^17,
    // x/125 as (x*M)>>22 exact for x < 2^15
    localparam logic [17:0] RECIP_127 = 18'd132105;
    localparam logic [15:0] RECIP_125 = 16'd33555;

    // decoded command classes
    typedef enum logic [3:0] {
        K_ON,
        K_OFF,
        K_TOGGLE,
        K_MTL,
        K_MOVE,
        K_STOP,
        K_TICK,
        K_RPT_ONOFF,
        K_RPT_LEVEL,
        K_NOP,
        K_MALFORMED,
        K_UNKNOWN
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        up;
        logic [7:0]  level;   // saturated target or decoded report level
        logic [9:0]  bright;  // brightness of the target
        logic        rpt_on;
    } cmd_t;

    typedef struct packed {
        logic [7:0] onoff_id;
        logic [7:0] level_id;
    } dp_ids_t;

    typedef struct packed {
        logic       write_valid;
        logic [7:0] write_id;
        logic       write_kind;
        logic [9:0] write_value;
        logic [1:0] status;
        logic       power_on;
        logic [7:0] dim_level;
        logic       level_changed;
        logic       onoff_changed;
        logic       last;
    } res_t;

    // level 0..254 -> brightness 0..1000, rounded:
    // (lv*1000+127)/254 == (lv*500+63)/127
    function automatic logic [9:0] to_bright(input logic [7:0] lv);
        logic [16:0] y;
        logic [34:0] p;
        y = ({lv, 9'd0}) - ({6'd0, lv, 3'd0}) - ({7'd0, lv, 2'd0}) + 17'd63;
        p = {18'd0, y} * {17'd0, RECIP_127};
        return p[33:24];
    endfunction

    // brightness 0..1000 -> level 0..254, rounded:
    // (v*254+500)/1000 == ((v*254+500)>>3)/125
    function automatic logic [7:0] from_bright(input logic [9:0] v);
        logic [17:0] x;
        logic [30:0] p;
        x = ({v, 8'd0}) - ({7'd0, v, 1'b0}) + 18'd500;
        p = {16'd0, x[17:3]} * {15'd0, RECIP_125};
        return p[29:22];
    endfunction

    function automatic dp_ids_t make_ids(input logic [3:0] ch,
                                         input logic [7:0] onoff_ovr,
                                         input logic [7:0] level_ovr);
        dp_ids_t ids;
        logic    ch_ok;
        ch_ok = (ch >= 4'd1) && (ch <= 4'd4);
        if (onoff_ovr != 8'd0)
            ids.onoff_id = onoff_ovr;
        else if (ch_ok)
            ids.onoff_id = {4'd0, ch};
        else
            ids.onoff_id = ONOFF_ID_DEF;
        if (level_ovr != 8'd0)
            ids.level_id = level_ovr;
        else if (ch_ok)
            ids.level_id = LEVEL_ID_BASE + {4'd0, ch};
        else
            ids.level_id = LEVEL_ID_DEF;
        return ids;
    endfunction

endpackage

// ===== rtl/dlrc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlrc_front
// Classifies an incoming transaction: payload checks, report matching and
// decoding, target saturation and brightness conversion.
// ----------------------------------------------------------------------------
module dlrc_front
    import dlrc_pkg::*;
(
    input  logic [3:0]  op,
    input  logic [7:0]  target_level,
    input  logic        move_up,
    input  logic [1:0]  payload_len,
    input  logic [7:0]  report_id,
    input  logic [1:0]  report_type,
    input  logic [31:0] report_bytes,
    input  logic [2:0]  report_len,
    input  dp_ids_t     ids,
    output cmd_t        cmd
);

    logic [7:0]  tgt_sat;
    logic [31:0] rpt_raw;
    logic [9:0]  rpt_clamped;

    assign tgt_sat = (target_level > LEVEL_MAX) ? LEVEL_MAX : target_level;

    // big endian decode of the first report_len bytes
    always_comb
    begin
        case (report_len)
            3'd0:    rpt_raw = 32'd0;
            3'd1:    rpt_raw = {24'd0, report_bytes[31:24]};
            3'd2:    rpt_raw = {16'd0, report_bytes[31:16]};
            3'd3:    rpt_raw = {8'd0, report_bytes[31:8]};
            default: rpt_raw = report_bytes;
        endcase
    end

    assign rpt_clamped = (rpt_raw > {22'd0, BRIGHT_MAX}) ? BRIGHT_MAX : rpt_raw[9:0];

    always_comb
    begin
        cmd.kind   = K_UNKNOWN;
        cmd.up     = move_up;
        cmd.level  = tgt_sat;
        cmd.bright = to_bright(tgt_sat);
        cmd.rpt_on = (report_bytes[31:24] != 8'd0);
        case (op)
            OP_ON:     cmd.kind = K_ON;
            OP_OFF:    cmd.kind = K_OFF;
            OP_TOGGLE: cmd.kind = K_TOGGLE;
            OP_MTL:    cmd.kind = (payload_len == 2'd0) ? K_MALFORMED : K_MTL;
            OP_MOVE:   cmd.kind = (payload_len < 2'd2) ? K_MALFORMED : K_MOVE;
            OP_STOP:   cmd.kind = K_STOP;
            OP_TICK:   cmd.kind = K_TICK;
            OP_REPORT:
            begin
                if (report_type == RPT_BOOL && report_id == ids.onoff_id)
                begin
                    cmd.kind = (report_len == 3'd0) ? K_NOP : K_RPT_ONOFF;
                end
                else if (report_type == RPT_VALUE && report_id == ids.level_id)
                begin
                    cmd.kind  = K_RPT_LEVEL;
                    cmd.level = from_bright(rpt_clamped);
                end
                else
                begin
                    cmd.kind = K_NOP;
                end
            end
            default:   cmd.kind = K_UNKNOWN;
        endcase
    end

endmodule

// ===== rtl/dlrc_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlrc_cmd_fifo
// Two-entry queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module dlrc_cmd_fifo
    import dlrc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic valid
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        cnt_next    = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== rtl/dlrc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlrc_back
// Executes classified commands against the dimmer state and queues the
// results, one per cycle while the result queue is not full.
// ----------------------------------------------------------------------------
module dlrc_back
    import dlrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    input  dp_ids_t ids,
    output res_t    res,
    output logic    empty,
    input  logic    pop
);

    logic       is_on_reg, is_on_next;
    logic [7:0] level_reg, level_next;
    logic       moving_reg, moving_next;
    logic       moving_up_reg, moving_up_next;
    logic       phase_reg, phase_next;

    res_t       q_reg [2];
    logic       q_wr_reg, q_wr_next;
    logic       q_rd_reg, q_rd_next;
    logic [1:0] q_cnt_reg, q_cnt_next;

    logic       emit;
    logic       q_full;
    logic       q_pop;
    logic [7:0] tick_lvl;
    res_t       r;

    assign q_full  = (q_cnt_reg == 2'd2);
    assign empty   = (q_cnt_reg == 2'd0);
    assign res     = q_reg[q_rd_reg];
    assign q_pop   = pop && !empty;
    assign emit    = cmd_valid && !q_full;
    assign cmd_pop = emit && ((cmd.kind != K_MTL) || phase_reg);

    // ramp one step toward the move direction, clamped at the limits
    always_comb
    begin
        tick_lvl = level_reg;
        if (moving_up_reg)
        begin
            if (level_reg < LEVEL_MAX)
                tick_lvl = ((LEVEL_MAX - level_reg) < RAMP_STEP) ? LEVEL_MAX
                                                                  : level_reg + RAMP_STEP;
        end
        else if (level_reg != 8'd0)
        begin
            tick_lvl = (level_reg < RAMP_STEP) ? 8'd0 : level_reg - RAMP_STEP;
        end
    end

    always_comb
    begin
        is_on_next     = is_on_reg;
        level_next     = level_reg;
        moving_next    = moving_reg;
        moving_up_next = moving_up_reg;
        phase_next     = phase_reg;
        r              = '0;
        r.last         = 1'b1;

        case (cmd.kind)
            K_ON,
            K_OFF,
            K_TOGGLE:
            begin
                if (cmd.kind == K_ON)
                    is_on_next = 1'b1;
                else if (cmd.kind == K_OFF)
                    is_on_next = 1'b0;
                else
                    is_on_next = !is_on_reg;
                r.write_valid = 1'b1;
                r.write_id    = ids.onoff_id;
                r.write_kind  = WK_BOOL;
                r.write_value = {9'd0, is_on_next};
            end
            K_MTL:
            begin
                r.write_valid = 1'b1;
                phase_next    = !phase_reg;
                if (!phase_reg)
                begin
                    level_next    = cmd.level;
                    is_on_next    = (cmd.level != 8'd0);
                    r.write_id    = ids.onoff_id;
                    r.write_kind  = WK_BOOL;
                    r.write_value = {9'd0, is_on_next};
                    r.last        = 1'b0;
                end
                else
                begin
                    r.write_id    = ids.level_id;
                    r.write_kind  = WK_VALUE;
                    r.write_value = cmd.bright;
                end
            end
            K_MOVE:
            begin
                moving_up_next = cmd.up;
                moving_next    = 1'b1;
                if (!is_on_reg && cmd.up)
                begin
                    is_on_next    = 1'b1;
                    r.write_valid = 1'b1;
                    r.write_id    = ids.onoff_id;
                    r.write_kind  = WK_BOOL;
                    r.write_value = 10'd1;
                end
            end
            K_STOP:
            begin
                moving_next = 1'b0;
            end
            K_TICK:
            begin
                if (moving_reg)
                begin
                    level_next = tick_lvl;
                    if (tick_lvl != level_reg)
                    begin
                        r.write_valid   = 1'b1;
                        r.write_id      = ids.level_id;
                        r.write_kind    = WK_VALUE;
                        r.write_value   = to_bright(tick_lvl);
                        r.level_changed = 1'b1;
                    end
                    if ((moving_up_reg && tick_lvl >= LEVEL_MAX) ||
                        (!moving_up_reg && tick_lvl == 8'd0))
                        moving_next = 1'b0;
                end
            end
            K_RPT_ONOFF:
            begin
                is_on_next      = cmd.rpt_on;
                r.onoff_changed = 1'b1;
            end
            K_RPT_LEVEL:
            begin
                level_next      = cmd.level;
                r.level_changed = 1'b1;
            end
            K_MALFORMED: r.status = ST_MALFORMED;
            K_UNKNOWN:   r.status = ST_UNKNOWN;
            default:     r.status = ST_OK;
        endcase

        r.power_on  = is_on_next;
        r.dim_level = level_next;

        if (!emit)
        begin
            is_on_next     = is_on_reg;
            level_next     = level_reg;
            moving_next    = moving_reg;
            moving_up_next = moving_up_reg;
            phase_next     = phase_reg;
        end

        q_wr_next  = q_wr_reg ^ emit;
        q_rd_next  = q_rd_reg ^ q_pop;
        q_cnt_next = q_cnt_reg + {1'b0, emit} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_on_reg     <= 1'b0;
            level_reg     <= 8'd0;
            moving_reg    <= 1'b0;
            moving_up_reg <= 1'b0;
            phase_reg     <= 1'b0;
            q_wr_reg      <= 1'b0;
            q_rd_reg      <= 1'b0;
            q_cnt_reg     <= 2'd0;
        end
        else
        begin
            is_on_reg     <= is_on_next;
            level_reg     <= level_next;
            moving_reg    <= moving_next;
            moving_up_reg <= moving_up_next;
            phase_reg     <= phase_next;
            q_wr_reg      <= q_wr_next;
            q_rd_reg      <= q_rd_next;
            q_cnt_reg     <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            q_reg[q_wr_reg] <= r;
    end

endmodule

// ===== rtl/dimmer_level_ramp_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dimmer_level_ramp_controller_top
// One-channel light dimmer: on/off/toggle, move-to-level, ramp moves driven
// by ticks, and power-stage reports, producing data point writes.
// ----------------------------------------------------------------------------
//
// Channel   Handshake                     Payload
// --------  ----------------------------  ---------------------------------
// command   push / full                   op, target_level, move_up,
//                                         payload_len, report_* fields
// result    empty / pop                   write_*, status, power_on,
//                                         dim_level, *_changed, last
// config    APB psel/penable/pwrite,      channel_number @0x0,
//           pready tied high              onoff_id_override @0x4,
//                                         level_id_override @0x8
//
// Flow: a command transaction is classified on entry and lands in a
// two-entry command queue; the back end issues results into a two-entry
// result queue, so a result is registered there after its command sits in
// the command queue. Move-to-level issues two results, an on/off write then
// a level write; all other commands issue one. Sustained rate: one result
// per cycle while the result queue is not full, set by the single issue port.
// Reset: rst_n clears the dimmer state (off, level 0, not moving), both
// queues, and sets the channel to 1 with no id overrides.
// Stalls: while pop is low the result queue fills, the back end holds, and
// full rises once the command queue holds two commands.
// ----------------------------------------------------------------------------
module dimmer_level_ramp_controller_top
    import dlrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // command queue side
    input  logic        push,
    output logic        full,
    input  logic [3:0]  op,
    input  logic [7:0]  target_level,
    input  logic        move_up,
    input  logic [1:0]  payload_len,
    input  logic [7:0]  report_id,
    input  logic [1:0]  report_type,
    input  logic [31:0] report_bytes,
    input  logic [2:0]  report_len,

    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic        write_valid,
    output logic [7:0]  write_id,
    output logic        write_kind,
    output logic [9:0]  write_value,
    output logic [1:0]  status,
    output logic        power_on,
    output logic [7:0]  dim_level,
    output logic        level_changed,
    output logic        onoff_changed,
    output logic        last,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [3:0] channel_reg, channel_next;
    logic [7:0] onoff_ovr_reg, onoff_ovr_next;
    logic [7:0] level_ovr_reg, level_ovr_next;
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    dp_ids_t ids;
    cmd_t    front_cmd;
    cmd_t    q_cmd;
    logic    q_valid;
    logic    q_pop;
    res_t    res;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_comb
    begin
        channel_next   = channel_reg;
        onoff_ovr_next = onoff_ovr_reg;
        level_ovr_next = level_ovr_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_CHANNEL:   channel_next   = pwdata[3:0];
                REG_ONOFF_OVR: onoff_ovr_next = pwdata[7:0];
                REG_LEVEL_OVR: level_ovr_next = pwdata[7:0];
                default:       channel_next   = channel_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_CHANNEL:   prdata = {28'd0, channel_reg};
            REG_ONOFF_OVR: prdata = {24'd0, onoff_ovr_reg};
            REG_LEVEL_OVR: prdata = {24'd0, level_ovr_reg};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_reg   <= CHANNEL_RESET;
            onoff_ovr_reg <= 8'd0;
            level_ovr_reg <= 8'd0;
        end
        else
        begin
            channel_reg   <= channel_next;
            onoff_ovr_reg <= onoff_ovr_next;
            level_ovr_reg <= level_ovr_next;
        end
    end

    // data point ids are to change only while the block is idle; not enforced here
    assign ids = make_ids(channel_reg, onoff_ovr_reg, level_ovr_reg);

    // front: classify the incoming transaction
    dlrc_front u_front (
        .op           (op),
        .target_level (target_level),
        .move_up      (move_up),
        .payload_len  (payload_len),
        .report_id    (report_id),
        .report_type  (report_type),
        .report_bytes (report_bytes),
        .report_len   (report_len),
        .ids          (ids),
        .cmd          (front_cmd)
    );

    // decouples classification from execution
    dlrc_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_cmd),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_cmd),
        .valid   (q_valid)
    );

    // back: state update and result issue
    dlrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_pop   (q_pop),
        .ids       (ids),
        .res       (res),
        .empty     (empty),
        .pop       (pop)
    );

    assign write_valid   = res.write_valid;
    assign write_id      = res.write_id;
    assign write_kind    = res.write_kind;
    assign write_value   = res.write_value;
    assign status        = res.status;
    assign power_on      = res.power_on;
    assign dim_level     = res.dim_level;
    assign level_changed = res.level_changed;
    assign onoff_changed = res.onoff_changed;
    assign last          = res.last;

endmodule

// ===== rtl/dlrc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlrc_checker
// Port-level checks of the dimmer controller result stream.
// ----------------------------------------------------------------------------
module dlrc_checker
    import dlrc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic       write_valid,
    input logic [7:0] write_id,
    input logic       write_kind,
    input logic [9:0] write_value,
    input logic [1:0] status,
    input logic       power_on,
    input logic [7:0] dim_level
);

    // error results never carry a write
    a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_OK) |-> !write_valid)
        else $error("error result carries a write");

    // write fields are zero without a write
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !write_valid) |->
            (write_id == 8'd0 && write_kind == WK_BOOL && write_value == 10'd0))
        else $error("write fields not cleared");

    // a bool write always reports the resulting on flag
    a_bool_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && write_valid && write_kind == WK_BOOL) |->
            (write_value == {9'd0, power_on}))
        else $error("bool write disagrees with power_on");

    // level and brightness stay in range
    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (dim_level <= LEVEL_MAX && write_value <= BRIGHT_MAX))
        else $error("level or brightness out of range");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(write_value) && $stable(status)))
        else $error("waiting result changed");

endmodule

bind dimmer_level_ramp_controller_top dlrc_checker u_dlrc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .write_valid   (write_valid),
    .write_id      (write_id),
    .write_kind    (write_kind),
    .write_value   (write_value),
    .status        (status),
    .power_on      (power_on),
    .dim_level     (dim_level)
);
